[src/lbc_pkg.sv]
// Shared constants for the LRU block cache: geometry, status codes and register indexes.
// No dependencies.
package lbc_pkg;
	localparam int MAX_ENTRIES     = 256;
	localparam int WORDS_PER_BLOCK = 32;
	localparam int SLOT_W  = $clog2(MAX_ENTRIES);
	localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
	localparam int WORD_W  = $clog2(WORDS_PER_BLOCK);
	localparam int WCNT_W  = $clog2(WORDS_PER_BLOCK + 1);
	localparam int DISK_W  = 4;
	localparam int BLK_W   = 8;
	localparam int KEY_W   = DISK_W + BLK_W;
	localparam int STAMP_W = 32;
	localparam int TAG_W   = KEY_W + STAMP_W;

	localparam logic [2:0] ST_HIT      = 3'd0;
	localparam logic [2:0] ST_MISS     = 3'd1;
	localparam logic [2:0] ST_INSERTED = 3'd2;
	localparam logic [2:0] ST_DUP      = 3'd3;
	localparam logic [2:0] ST_REJECT   = 3'd4;

	localparam logic REQ_LOOKUP = 1'b0;
	localparam logic REG_CACHE_ON = 1'b0;
	localparam logic REG_ENTRIES  = 1'b1;
endpackage

[src/lbc_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module lbc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end
endmodule

[src/lru_block_cache.sv]
// LRU block cache top level: sequencer, tag scan, staging and block memories, APB registers.
// Depends on lbc_pkg and lbc_ram.
//
// A transaction is taken when start is high and busy is low; results cannot be held off.
// A non-final insert beat is written to the staging memory while the cache is on and gives no result.
// A disabled or rejected request gives its result in the cycle after it is accepted. Otherwise the
// tag memory is scanned one slot a cycle (n = entries_in_use clamped to 2..256 slots, stopping at
// the first match); then a hit streams 32 words, and an insert copies the staged block before its
// single result.
module lru_block_cache
	import lbc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        req_type,
	input  logic [4:0]  disk_id,
	input  logic [8:0]  block_id,
	input  logic [4:0]  word_index,
	input  logic [63:0] data_word,
	input  logic        last_beat,
	output logic        strobe,
	output logic [2:0]  status,
	output logic [63:0] out_word,
	output logic [4:0]  out_index,
	output logic        last_result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SCAN   = 3'd1;
	localparam logic [2:0] S_COPY   = 3'd2;
	localparam logic [2:0] S_STREAM = 3'd3;
	localparam logic [2:0] S_RESP   = 3'd4;

	logic [2:0]             state_q;
	logic                   cache_on_q;
	logic [8:0]             entries_q;
	logic [MAX_ENTRIES-1:0] valid_q;
	logic [CNT_W-1:0]       fill_q;
	logic [STAMP_W-1:0]     clock_q;
	logic                   req_q;
	logic [KEY_W-1:0]       key_q;
	logic [2:0]             res_status_q;
	logic [SLOT_W-1:0]      slot_q;
	logic [CNT_W-1:0]       scan_idx_q;
	logic                   cmp_vld_s1;
	logic                   cmp_last_s1;
	logic [SLOT_W-1:0]      cmp_idx_s1;
	logic [STAMP_W-1:0]     best_q;
	logic [SLOT_W-1:0]      best_idx_q;
	logic [WCNT_W-1:0]      cnt_q;
	logic                   mv_vld_s1;
	logic [WORD_W-1:0]      mv_k_s1;

	logic [CNT_W-1:0]   n_slots;
	logic               accept, cfg_wr, key_ok, issue, match;
	logic [STAMP_W-1:0] best_nxt;
	logic [SLOT_W-1:0]  best_idx_nxt, ins_slot;
	logic [TAG_W-1:0]   tag_rd;
	logic               tag_we;
	logic [SLOT_W-1:0]  tag_wa;
	logic [63:0]        stg_rd, blk_rd;
	logic [SLOT_W+WORD_W-1:0] blk_ra;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (paddr[2] == REG_ENTRIES) ? {23'd0, entries_q} : {31'd0, cache_on_q};
	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign key_ok = (disk_id[4] == 1'b0) && (block_id[8] == 1'b0);

	always_comb begin
		if (entries_q < 9'd2) begin
			n_slots = CNT_W'(2);
		end else if (CNT_W'(entries_q) > CNT_W'(MAX_ENTRIES) || entries_q > 9'(MAX_ENTRIES)) begin
			n_slots = CNT_W'(MAX_ENTRIES);
		end else begin
			n_slots = CNT_W'(entries_q);
		end
	end

	assign issue = (state_q == S_SCAN) && (scan_idx_q < n_slots);
	assign match = cmp_vld_s1 && valid_q[cmp_idx_s1] && (tag_rd[TAG_W-1:STAMP_W] == key_q);

	always_comb begin
		best_nxt     = best_q;
		best_idx_nxt = best_idx_q;
		if (cmp_vld_s1 && (cmp_idx_s1 == '0 || tag_rd[STAMP_W-1:0] < best_q)) begin
			best_nxt     = tag_rd[STAMP_W-1:0];
			best_idx_nxt = cmp_idx_s1;
		end
	end

	assign ins_slot = (fill_q < n_slots) ? fill_q[SLOT_W-1:0] : best_idx_nxt;
	assign tag_we   = (state_q == S_SCAN) && cmp_vld_s1 && (match || (cmp_last_s1 && req_q));
	assign tag_wa   = match ? cmp_idx_s1 : ins_slot;
	assign blk_ra   = {slot_q, cnt_q[WORD_W-1:0]};

	lbc_ram #(.WIDTH(TAG_W), .DEPTH(MAX_ENTRIES)) u_tag_ram (
		.clk(clk), .wr_en(tag_we), .wr_addr(tag_wa), .wr_data({key_q, clock_q}),
		.rd_addr(scan_idx_q[SLOT_W-1:0]), .rd_data(tag_rd)
	);

	lbc_ram #(.WIDTH(64), .DEPTH(WORDS_PER_BLOCK)) u_stg_ram (
		.clk(clk),
		.wr_en(accept && req_type != REQ_LOOKUP && cache_on_q
			&& 32'(word_index) < 32'(WORDS_PER_BLOCK)),
		.wr_addr(word_index[WORD_W-1:0]), .wr_data(data_word),
		.rd_addr(cnt_q[WORD_W-1:0]), .rd_data(stg_rd)
	);

	lbc_ram #(.WIDTH(64), .DEPTH(MAX_ENTRIES * WORDS_PER_BLOCK)) u_blk_ram (
		.clk(clk), .wr_en((state_q == S_COPY) && mv_vld_s1),
		.wr_addr({slot_q, mv_k_s1}), .wr_data(stg_rd),
		.rd_addr(blk_ra), .rd_data(blk_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cache_on_q   <= 1'b0;
			entries_q    <= 9'd2;
			valid_q      <= '0;
			fill_q       <= '0;
			clock_q      <= '0;
			cmp_vld_s1   <= 1'b0;
			mv_vld_s1    <= 1'b0;
			scan_idx_q   <= '0;
			cnt_q        <= '0;
			res_status_q <= ST_MISS;
			slot_q       <= '0;
			best_q       <= '0;
			best_idx_q   <= '0;
		end else begin
			if (cfg_wr) begin
				if (paddr[2] == REG_CACHE_ON) begin
					// enabling an off cache empties it
					if (pwdata[0] && !cache_on_q) begin
						valid_q <= '0;
						fill_q  <= '0;
						clock_q <= '0;
					end
					cache_on_q <= pwdata[0];
				end else begin
					entries_q <= pwdata[8:0];
				end
			end
			cmp_vld_s1 <= issue;
			if (issue) begin
				scan_idx_q <= scan_idx_q + 1'b1;
			end
			mv_vld_s1 <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept && (req_type == REQ_LOOKUP || last_beat)) begin
						scan_idx_q <= '0;
						if (!cache_on_q) begin
							res_status_q <= ST_MISS;
							state_q      <= S_RESP;
						end else if (!key_ok) begin
							res_status_q <= ST_REJECT;
							state_q      <= S_RESP;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (cmp_vld_s1) begin
						best_q     <= best_nxt;
						best_idx_q <= best_idx_nxt;
					end
					if (match) begin
						slot_q  <= cmp_idx_s1;
						clock_q <= clock_q + 1'b1;
						cnt_q   <= '0;
						if (req_q == REQ_LOOKUP) begin
							state_q <= S_STREAM;
						end else begin
							res_status_q <= ST_DUP;
							state_q      <= S_COPY;
						end
					end else if (cmp_vld_s1 && cmp_last_s1) begin
						if (req_q == REQ_LOOKUP) begin
							res_status_q <= ST_MISS;
							state_q      <= S_RESP;
						end else begin
							// take the next free slot, else evict the oldest stamp
							slot_q            <= ins_slot;
							valid_q[ins_slot] <= 1'b1;
							if (fill_q < n_slots) begin
								fill_q <= fill_q + 1'b1;
							end
							clock_q      <= clock_q + 1'b1;
							cnt_q        <= '0;
							res_status_q <= ST_INSERTED;
							state_q      <= S_COPY;
						end
					end
				end
				S_COPY, S_STREAM: begin
					if (cnt_q < WCNT_W'(WORDS_PER_BLOCK)) begin
						cnt_q     <= cnt_q + 1'b1;
						mv_vld_s1 <= 1'b1;
					end else begin
						// the last word moves in this cycle
						state_q <= (state_q == S_COPY) ? S_RESP : S_IDLE;
					end
				end
				S_RESP: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req_type;
			key_q <= {disk_id[DISK_W-1:0], block_id[BLK_W-1:0]};
		end
		cmp_idx_s1  <= scan_idx_q[SLOT_W-1:0];
		cmp_last_s1 <= (scan_idx_q == n_slots - 1'b1);
		mv_k_s1     <= cnt_q[WORD_W-1:0];
	end

	logic stream_out;
	assign stream_out  = (state_q == S_STREAM) && mv_vld_s1;
	assign strobe      = (state_q == S_RESP) || stream_out;
	assign status      = stream_out ? ST_HIT : res_status_q;
	assign out_word    = stream_out ? blk_rd : 64'd0;
	assign out_index   = stream_out ? 5'(mv_k_s1) : 5'd0;
	assign last_result = (state_q == S_RESP)
		|| (stream_out && mv_k_s1 == WORD_W'(WORDS_PER_BLOCK - 1));

`ifndef SYNTHESIS
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (req_type == REQ_LOOKUP || last_beat) |=> busy)
		else $error("request did not raise busy");
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(MAX_ENTRIES))
		else $error("fill count beyond depth");
	a_hit_word: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last_result |-> status == ST_HIT)
		else $error("non-final result that is not a hit word");
	a_idle_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last_result |=> !busy)
		else $error("still busy after final result");
`endif
endmodule
